>>> hw/rtl/sat_pkg.sv
`timescale 1ns / 1ps

package sat_pkg;

    // operation codes of an input word
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_REUSED = 2'd0;
    localparam logic [1:0] ST_NEW    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_FREED  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_RESERVED = 2'd0;
    localparam logic [1:0] CFG_RELAX    = 2'd1;
    localparam logic [1:0] CFG_GRACE    = 2'd2;

    // configuration reset values (2.0 s and 0.5 s at 1/1024 s per unit)
    localparam logic [10:0] RESERVED_RST = 11'd0;
    localparam logic [31:0] RELAX_RST    = 32'd2048;
    localparam logic [31:0] GRACE_RST    = 32'd512;

    typedef struct packed {
        logic        op;
        logic [9:0]  slot_index;
        logic [31:0] now_time;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot;
        logic [31:0] serial;
    } t_out_word;

    // one table entry as held by a cell
    typedef struct packed {
        logic        free;
        logic [31:0] stamp;
        logic [31:0] serial;
    } t_entry;

    localparam t_entry ENTRY_RST = '{free: 1'b1, stamp: 32'd0, serial: 32'd0};

    // what the head found at the entry passing it
    typedef struct packed {
        logic claim_reuse;
        logic claim_new;
        logic free_hit;
    } t_hit;

endpackage

>>> hw/rtl/sat_cell.sv
`timescale 1ns / 1ps

module sat_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  sat_pkg::t_entry i_entry,
    output sat_pkg::t_entry o_entry
);

    sat_pkg::t_entry r_entry;

    // take the neighbour's entry on every shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= sat_pkg::ENTRY_RST;
        end else if (i_en) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> hw/rtl/sat_head.sv
`timescale 1ns / 1ps

module sat_head #(
    parameter int MW = 15
) (
    input  sat_pkg::t_entry i_entry,
    input  logic [MW-1:0]   i_pos,
    input  logic [MW-1:0]   i_mark,
    input  logic [10:0]     i_reserved,
    input  logic [31:0]     i_relax,
    input  logic [31:0]     i_grace,
    input  sat_pkg::t_in_word i_item,
    input  logic            i_found,
    output sat_pkg::t_entry o_entry,
    output sat_pkg::t_hit   o_hit
);

    logic            w_in_scan;
    logic            w_qualifies;
    logic            w_alloc;
    logic [31:0]     w_age;
    sat_pkg::t_entry w_entry;

    // age of a freed slot, zero when time has run backward
    assign w_age = (i_item.now_time > i_entry.stamp) ? (i_item.now_time - i_entry.stamp)
                                                      : 32'd0;

    assign w_qualifies = i_entry.free &&
                         ((i_entry.stamp < i_relax) || (w_age > i_grace));

    assign w_in_scan = (i_pos >= MW'(i_reserved)) && (i_pos < i_mark);
    assign w_alloc   = (i_item.op == sat_pkg::OP_ALLOC) && !i_found;

    assign o_hit.claim_reuse = w_alloc && w_in_scan && w_qualifies;
    assign o_hit.claim_new   = w_alloc && (i_pos == i_mark);
    assign o_hit.free_hit    = (i_item.op == sat_pkg::OP_FREE) &&
                               (i_pos == MW'(i_item.slot_index));

    // update the entry on its way back into the chain
    always_comb begin
        w_entry = i_entry;
        if (o_hit.claim_reuse || o_hit.claim_new) begin
            w_entry.free = 1'b0;
        end else if (o_hit.free_hit && !i_entry.free) begin
            w_entry.free   = 1'b1;
            w_entry.stamp  = i_item.now_time;
            w_entry.serial = i_entry.serial + 32'd1;
        end
    end

    assign o_entry = w_entry;

endmodule

>>> hw/rtl/slot_allocator_timed_reuse_core.sv
// Each accepted word circulates the table once through the ring of cells
// past the single head, waits in a hold state while the output is stalled,
// and its result is then registered out; no new word is taken until then.
// Reset (synchronous, active low) frees every slot, clears stamps, serials
// and the high-water count at once, and restores the configuration registers.
`timescale 1ns / 1ps

module slot_allocator_timed_reuse_core #(
    parameter int SLOTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sat_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sat_pkg::t_out_word  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UW = $clog2(SLOTS + 1);
    localparam int MW = ((UW > 11) ? UW : 11) + 1;
    localparam logic [CW-1:0] LAST = CW'(SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]          r_state;
    logic [CW-1:0]       r_pos;
    logic [UW-1:0]       r_used;
    logic                r_found;
    logic [10:0]         r_reserved;
    logic [31:0]         r_relax;
    logic [31:0]         r_grace;
    sat_pkg::t_in_word   r_item;
    sat_pkg::t_out_word  r_res;
    sat_pkg::t_out_word  n_res;
    logic                r_out_valid;
    sat_pkg::t_out_word  r_out;

    logic                w_accept;
    logic                w_shift;
    logic                w_last;
    logic                w_out_free;
    logic                w_load;
    logic [MW-1:0]       w_pos_x;
    logic [MW-1:0]       w_mark;
    sat_pkg::t_entry     w_head_entry;
    sat_pkg::t_hit       w_hit;
    sat_pkg::t_entry     w_chain [SLOTS];

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_shift    = (r_state == S_SCAN);
    assign w_last     = w_shift && (r_pos == LAST);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (w_last && w_out_free) || ((r_state == S_HOLD) && w_out_free);
    assign w_pos_x    = MW'(r_pos);
    assign w_mark     = MW'(r_reserved) + MW'(r_used);

    // ring of cells: slot 0 sits at the far end when the ring is at rest
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        if (k == 0) begin : g_first
            sat_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_shift),
                .i_entry (w_head_entry),
                .o_entry (w_chain[k])
            );
        end else begin : g_next
            sat_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_shift),
                .i_entry (w_chain[k-1]),
                .o_entry (w_chain[k])
            );
        end
    end

    sat_head #(
        .MW (MW)
    ) u_head (
        .i_entry    (w_chain[SLOTS-1]),
        .i_pos      (w_pos_x),
        .i_mark     (w_mark),
        .i_reserved (r_reserved),
        .i_relax    (r_relax),
        .i_grace    (r_grace),
        .i_item     (r_item),
        .i_found    (r_found),
        .o_entry    (w_head_entry),
        .o_hit      (w_hit)
    );

    // fold the head's findings into the pending result
    always_comb begin
        n_res = r_res;
        if (w_hit.claim_reuse) begin
            n_res.status = sat_pkg::ST_REUSED;
            n_res.slot   = w_pos_x[9:0];
            n_res.serial = w_head_entry.serial;
        end else if (w_hit.claim_new) begin
            n_res.status = sat_pkg::ST_NEW;
            n_res.slot   = w_pos_x[9:0];
            n_res.serial = w_head_entry.serial;
        end else if (w_hit.free_hit) begin
            n_res.serial = w_head_entry.serial;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved <= sat_pkg::RESERVED_RST;
            r_relax    <= sat_pkg::RELAX_RST;
            r_grace    <= sat_pkg::GRACE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sat_pkg::CFG_RESERVED: r_reserved <= i_cfg_data[10:0];
                sat_pkg::CFG_RELAX:    r_relax    <= i_cfg_data;
                sat_pkg::CFG_GRACE:    r_grace    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: accept, circulate the ring once, hand over the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_used  <= '0;
            r_found <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                        r_pos   <= '0;
                        r_found <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_found <= r_found || w_hit.claim_reuse || w_hit.claim_new;
                    if (w_hit.claim_new) begin
                        r_used <= r_used + UW'(1);
                    end
                    if (w_last) begin
                        r_pos   <= '0;
                        r_state <= w_out_free ? S_IDLE : S_HOLD;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // hold the accepted word and the pending result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
            if (i_in_data.op == sat_pkg::OP_FREE) begin
                r_res <= '{status: sat_pkg::ST_FREED, slot: i_in_data.slot_index,
                           serial: 32'd0};
            end else begin
                r_res <= '{status: sat_pkg::ST_FULL, slot: 10'd0, serial: 32'd0};
            end
        end else if (w_shift) begin
            r_res <= n_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_shift ? n_res : r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SCAN))
        else $error("scan did not start after an accepted word");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pos == LAST) |=> (r_state != S_SCAN))
        else $error("scan ran past the last slot");

    a_used_only_on_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_used != $past(r_used)) |-> $past(w_hit.claim_new))
        else $error("high-water count moved without a new slot");

    a_out_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) != S_IDLE))
        else $error("result appeared without a scan");
`endif

endmodule
